// ----- rtl/per_frame_request_budget_limiter_macros.svh -----
// assertion macros for the request budget limiter
`ifndef PER_FRAME_REQUEST_BUDGET_LIMITER_MACROS_SVH
`define PER_FRAME_REQUEST_BUDGET_LIMITER_MACROS_SVH

`ifndef ASSERT_OFF
`define PRBL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PRBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRBL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PRBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/prbl_pkg.sv -----
`default_nettype none
package prbl_pkg;

  localparam int PLAYERS_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int OUT_W          = 16;
  localparam int FRAME_W        = 32;
  localparam int CFG_IDX_W      = 4;

  localparam logic [2:0] OP_GROUP_LONG  = 3'd0;
  localparam logic [2:0] OP_GROUP_SHORT = 3'd1;
  localparam logic [2:0] OP_UNIT        = 3'd2;
  localparam logic [2:0] OP_TICK        = 3'd3;
  localparam logic [2:0] OP_QUERY       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_GROUP_BUDGET = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_BUDGET  = 4'd1;

  localparam logic [15:0] GROUP_BUDGET_RST = 16'd16;
  localparam logic [15:0] UNIT_BUDGET_RST  = 16'd16;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] requester;
  } prbl_in_t;

  typedef struct packed {
    logic               granted;
    logic [OUT_W-1:0]   platoon_denied_count;
    logic [OUT_W-1:0]   squad_denied_count;
    logic [OUT_W-1:0]   platoon_run;
    logic [OUT_W-1:0]   platoon_run_max;
    logic [OUT_W-1:0]   squad_run;
    logic [OUT_W-1:0]   squad_run_max;
    logic [OUT_W-1:0]   long_peak_seen;
    logic [OUT_W-1:0]   short_peak_seen;
    logic [OUT_W-1:0]   squad_peak_seen;
    logic [FRAME_W-1:0] frames_seen;
  } prbl_out_t;

  typedef struct packed {
    logic       fire;
    logic       req_long;
    logic       req_short;
    logic       req_unit;
    logic       tick;
    logic [3:0] requester;
  } prbl_ctl_t;

  typedef struct packed {
    logic grp_deny;
    logic unit_deny;
  } prbl_judge_t;

  typedef struct packed {
    logic [OUT_W-1:0] platoon_denied_count;
    logic [OUT_W-1:0] squad_denied_count;
    logic [OUT_W-1:0] platoon_run;
    logic [OUT_W-1:0] platoon_run_max;
    logic [OUT_W-1:0] squad_run;
    logic [OUT_W-1:0] squad_run_max;
  } prbl_view_t;

endpackage
`default_nettype wire

// ----- rtl/prbl_frame_stats.sv -----
`default_nettype none
module prbl_frame_stats #(
  parameter int COUNT_BITS = prbl_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire prbl_pkg::prbl_ctl_t            ctl,
  input  wire logic [15:0]                    group_budget,
  input  wire logic [15:0]                    unit_budget,
  output prbl_pkg::prbl_judge_t               judge,
  output logic [prbl_pkg::OUT_W-1:0]          long_peak,
  output logic [prbl_pkg::OUT_W-1:0]          short_peak,
  output logic [prbl_pkg::OUT_W-1:0]          squad_peak,
  output logic [prbl_pkg::FRAME_W-1:0]        frames
);
  import prbl_pkg::*;

  localparam int CW = COUNT_BITS + 17;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  logic [COUNT_BITS-1:0] long_r, short_r, unit_r;
  logic [COUNT_BITS-1:0] long_peak_r, short_peak_r, unit_peak_r;
  logic [FRAME_W-1:0]    frames_r;

  logic [COUNT_BITS-1:0] long_inc, short_inc, unit_inc;
  logic [COUNT_BITS-1:0] long_nxt, short_nxt, unit_nxt;
  logic [COUNT_BITS-1:0] long_peak_nxt, short_peak_nxt, unit_peak_nxt;
  logic [FRAME_W-1:0]    frames_nxt;
  logic [CW-1:0]         group_sum;

  always_comb begin
    long_inc  = ctl.req_long  ? sat_inc(long_r)  : long_r;
    short_inc = ctl.req_short ? sat_inc(short_r) : short_r;
    unit_inc  = ctl.req_unit  ? sat_inc(unit_r)  : unit_r;
    group_sum = CW'(long_inc) + CW'(short_inc);
    judge.grp_deny  = group_sum >= CW'(group_budget);
    judge.unit_deny = CW'(unit_inc) >= CW'(unit_budget);
    long_peak_nxt  = (long_inc  > long_peak_r)  ? long_inc  : long_peak_r;
    short_peak_nxt = (short_inc > short_peak_r) ? short_inc : short_peak_r;
    unit_peak_nxt  = (unit_inc  > unit_peak_r)  ? unit_inc  : unit_peak_r;
    long_nxt  = ctl.tick ? '0 : long_inc;
    short_nxt = ctl.tick ? '0 : short_inc;
    unit_nxt  = ctl.tick ? '0 : unit_inc;
    frames_nxt = (ctl.tick && frames_r != {FRAME_W{1'b1}}) ?
                 frames_r + FRAME_W'(1) : frames_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r       <= '0;
      short_r      <= '0;
      unit_r       <= '0;
      long_peak_r  <= '0;
      short_peak_r <= '0;
      unit_peak_r  <= '0;
      frames_r     <= '0;
    end else if (ctl.fire) begin
      long_r       <= long_nxt;
      short_r      <= short_nxt;
      unit_r       <= unit_nxt;
      long_peak_r  <= long_peak_nxt;
      short_peak_r <= short_peak_nxt;
      unit_peak_r  <= unit_peak_nxt;
      frames_r     <= frames_nxt;
    end
  end

  // results reflect the state after this beat
  assign long_peak  = OUT_W'(long_peak_nxt);
  assign short_peak = OUT_W'(short_peak_nxt);
  assign squad_peak = OUT_W'(unit_peak_nxt);
  assign frames     = frames_nxt;

endmodule
`default_nettype wire

// ----- rtl/prbl_player_bank.sv -----
`default_nettype none
module prbl_player_bank #(
  parameter int PLAYERS    = prbl_pkg::PLAYERS_DEF,
  parameter int COUNT_BITS = prbl_pkg::COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire prbl_pkg::prbl_ctl_t   ctl,
  input  wire prbl_pkg::prbl_judge_t judge,
  output prbl_pkg::prbl_view_t       view
);
  import prbl_pkg::*;

  localparam int IW = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  logic [COUNT_BITS-1:0] pden_r [PLAYERS];
  logic [COUNT_BITS-1:0] sden_r [PLAYERS];
  logic [COUNT_BITS-1:0] prun_r [PLAYERS];
  logic [COUNT_BITS-1:0] pmax_r [PLAYERS];
  logic [COUNT_BITS-1:0] srun_r [PLAYERS];
  logic [COUNT_BITS-1:0] smax_r [PLAYERS];

  logic [COUNT_BITS-1:0] pden_nxt [PLAYERS];
  logic [COUNT_BITS-1:0] sden_nxt [PLAYERS];
  logic [COUNT_BITS-1:0] prun_nxt [PLAYERS];
  logic [COUNT_BITS-1:0] pmax_nxt [PLAYERS];
  logic [COUNT_BITS-1:0] srun_nxt [PLAYERS];
  logic [COUNT_BITS-1:0] smax_nxt [PLAYERS];

  logic          known;
  logic [IW-1:0] idx;
  logic          pden_hit, sden_hit;

  assign known    = 32'(ctl.requester) < PLAYERS;
  assign idx      = IW'(ctl.requester);
  assign pden_hit = known && (ctl.req_long || ctl.req_short) && judge.grp_deny;
  assign sden_hit = known && ctl.req_unit && judge.unit_deny;

  always_comb begin
    for (int i = 0; i < PLAYERS; i++) begin
      pden_nxt[i] = pden_r[i];
      sden_nxt[i] = sden_r[i];
      prun_nxt[i] = prun_r[i];
      pmax_nxt[i] = pmax_r[i];
      srun_nxt[i] = srun_r[i];
      smax_nxt[i] = smax_r[i];
      if (ctl.tick) begin
        // close the frame: extend or end each denial run
        if (pden_r[i] != '0) begin
          prun_nxt[i] = sat_inc(prun_r[i]);
        end else begin
          if (prun_r[i] > pmax_r[i]) pmax_nxt[i] = prun_r[i];
          prun_nxt[i] = '0;
        end
        if (sden_r[i] != '0) begin
          srun_nxt[i] = sat_inc(srun_r[i]);
        end else begin
          if (srun_r[i] > smax_r[i]) smax_nxt[i] = srun_r[i];
          srun_nxt[i] = '0;
        end
        pden_nxt[i] = '0;
        sden_nxt[i] = '0;
      end else begin
        if (pden_hit && idx == IW'(i)) pden_nxt[i] = sat_inc(pden_r[i]);
        if (sden_hit && idx == IW'(i)) sden_nxt[i] = sat_inc(sden_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PLAYERS; i++) begin
        pden_r[i] <= '0;
        sden_r[i] <= '0;
        prun_r[i] <= '0;
        pmax_r[i] <= '0;
        srun_r[i] <= '0;
        smax_r[i] <= '0;
      end
    end else if (ctl.fire) begin
      for (int i = 0; i < PLAYERS; i++) begin
        pden_r[i] <= pden_nxt[i];
        sden_r[i] <= sden_nxt[i];
        prun_r[i] <= prun_nxt[i];
        pmax_r[i] <= pmax_nxt[i];
        srun_r[i] <= srun_nxt[i];
        smax_r[i] <= smax_nxt[i];
      end
    end
  end

  always_comb begin
    if (known) begin
      view.platoon_denied_count = OUT_W'(pden_nxt[idx]);
      view.squad_denied_count   = OUT_W'(sden_nxt[idx]);
      view.platoon_run          = OUT_W'(prun_nxt[idx]);
      view.platoon_run_max      = OUT_W'(pmax_nxt[idx]);
      view.squad_run            = OUT_W'(srun_nxt[idx]);
      view.squad_run_max        = OUT_W'(smax_nxt[idx]);
    end else begin
      view = '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/per_frame_request_budget_limiter.sv -----
// per-frame request budget limiter
// an input beat passes the input register, then the result register; all requesters close
// their frame in parallel on a tick; one item per cycle unless out_stall holds the output
// reset: synchronous active-low rst_n clears all counters, runs, peaks and the frame count,
//   and loads both budgets with 16; no clearing pass, items are taken right after reset
`default_nettype none
`include "per_frame_request_budget_limiter_macros.svh"
module per_frame_request_budget_limiter #(
  parameter int PLAYERS    = prbl_pkg::PLAYERS_DEF,
  parameter int COUNT_BITS = prbl_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire prbl_pkg::prbl_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output prbl_pkg::prbl_out_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [prbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [15:0]                      cfg_data
);
  import prbl_pkg::*;

  logic [15:0] group_budget_r, unit_budget_r;
  logic        s1_valid_r;
  prbl_in_t    s1_data_r;
  logic        out_valid_r;
  prbl_out_t   out_data_r, out_data_nxt;
  logic        out_free, fire, accept;
  prbl_ctl_t   ctl;
  prbl_judge_t judge;
  prbl_view_t  view;
  logic [OUT_W-1:0]   long_peak, short_peak, squad_peak;
  logic [FRAME_W-1:0] frames;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_budget_r <= GROUP_BUDGET_RST;
      unit_budget_r  <= UNIT_BUDGET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GROUP_BUDGET: group_budget_r <= cfg_data;
        REG_UNIT_BUDGET:  unit_budget_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_data_r <= in_data;
  end

  always_comb begin
    ctl           = '0;
    ctl.fire      = fire;
    ctl.requester = s1_data_r.requester;
    case (s1_data_r.operation)
      OP_GROUP_LONG:  ctl.req_long  = 1'b1;
      OP_GROUP_SHORT: ctl.req_short = 1'b1;
      OP_UNIT:        ctl.req_unit  = 1'b1;
      OP_TICK:        ctl.tick      = 1'b1;
      OP_QUERY:       ;
      default:        ;
    endcase
  end

  prbl_frame_stats #(
    .COUNT_BITS(COUNT_BITS)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .group_budget(group_budget_r),
    .unit_budget (unit_budget_r),
    .judge       (judge),
    .long_peak   (long_peak),
    .short_peak  (short_peak),
    .squad_peak  (squad_peak),
    .frames      (frames)
  );

  prbl_player_bank #(
    .PLAYERS   (PLAYERS),
    .COUNT_BITS(COUNT_BITS)
  ) u_bank (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .judge(judge),
    .view (view)
  );

  always_comb begin
    out_data_nxt.granted = ((ctl.req_long || ctl.req_short) && !judge.grp_deny) ||
                           (ctl.req_unit && !judge.unit_deny);
    out_data_nxt.platoon_denied_count = view.platoon_denied_count;
    out_data_nxt.squad_denied_count   = view.squad_denied_count;
    out_data_nxt.platoon_run          = view.platoon_run;
    out_data_nxt.platoon_run_max      = view.platoon_run_max;
    out_data_nxt.squad_run            = view.squad_run;
    out_data_nxt.squad_run_max        = view.squad_run_max;
    out_data_nxt.long_peak_seen       = long_peak;
    out_data_nxt.short_peak_seen      = short_peak;
    out_data_nxt.squad_peak_seen      = squad_peak;
    out_data_nxt.frames_seen          = frames;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PRBL_ASSERT_IMPLY(a_stall_has_item, clk, rst_n, in_stall, s1_valid_r, "stall without held item")
  `PRBL_ASSERT_NEXT(a_held_item_stays, clk, rst_n, s1_valid_r && !out_free, s1_valid_r, "held item lost")
  `PRBL_ASSERT_NEXT(a_tick_counts, clk, rst_n, fire && ctl.tick, out_data_r.frames_seen != '0, "tick not counted")
  `PRBL_ASSERT_NEXT(a_no_grant_idle, clk, rst_n, fire && !ctl.req_long && !ctl.req_short && !ctl.req_unit, !out_data_r.granted, "grant on non-request")

endmodule
`default_nettype wire
